### rtl/ssc_pkg.sv
// Shared constants, types and helpers for the stream source cell finder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

    localparam int MAX_COLS_DEF = 4096;
    localparam int ID_BITS_DEF  = 16;

    localparam int ID_W    = 16;
    localparam int DIR_W   = 5;
    localparam int ROW_W   = 16;
    localparam int COL_W   = 12;
    localparam int CFG_W   = 13;
    localparam int CNT_W   = 4;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = CFG_W'(4096);

    localparam logic [CNT_W-1:0] DENSE_LIMIT    = CNT_W'(3);
    localparam logic [CNT_W-1:0] MISMATCH_LIMIT = CNT_W'(5);

    localparam int RES_DEPTH = 4;
    localparam int RES_PW    = 2;

    localparam int ROW_OFF [9] = '{0, -1, -1, -1, 0, 1, 1, 1, 0};
    localparam int COL_OFF [9] = '{0, 1, 0, -1, -1, -1, 0, 1, 1};

    typedef struct packed {
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic [ID_W-1:0]  cell_stream;
        logic [CNT_W-1:0] inflow_count;
        logic             dense_flag;
        logic             mismatch_flag;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    a;
        result_t    b;
    } push_t;

    // direction a neighbor must carry to drain into the center
    function automatic logic [DIR_W-1:0] want_dir(input int i);
        int w;
        w = (i + 4 > 8) ? i - 4 : i + 4;
        return DIR_W'(w);
    endfunction

endpackage

`default_nettype wire

### rtl/ssc_stream_if.sv
// Valid/ready channels for pixel words in and result words out.
// Depends on ssc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ssc_pixel_if;
    import ssc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ID_W-1:0]         stream_id;
    logic signed [DIR_W-1:0] flow_dir;
    logic                    padding;

    modport source (output valid, output stream_id, output flow_dir, output padding,
                    input ready);
    modport sink   (input valid, input stream_id, input flow_dir, input padding,
                    output ready);
endinterface

interface ssc_result_if;
    import ssc_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic [ID_W-1:0]  cell_stream;
    logic [CNT_W-1:0] inflow_count;
    logic             dense_flag;
    logic             mismatch_flag;
    logic             last;

    modport source (output valid, output cell_row, output cell_col, output cell_stream,
                    output inflow_count, output dense_flag, output mismatch_flag,
                    output last, input ready);
    modport sink   (input valid, input cell_row, input cell_col, input cell_stream,
                    input inflow_count, input dense_flag, input mismatch_flag,
                    input last, output ready);
endinterface

`default_nettype wire

### rtl/ssc_line_store.sv
// Two raster line stores packed in one memory word, with read prefetch,
// write bypass and a clearing sweep after reset. Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_line_store #(
    parameter int  MAX_COLS = ssc_pkg::MAX_COLS_DEF,
    parameter int  CELL_W   = ssc_pkg::ID_BITS_DEF + ssc_pkg::DIR_W,
    localparam int AW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hold,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [AW-1:0]       rd_addr,
    input  logic [CELL_W-1:0]   wr_cell,
    output logic [2*CELL_W-1:0] line_data,
    output logic                ready
);
    import ssc_pkg::*;

    logic [2*CELL_W-1:0] mem [MAX_COLS];
    logic [2*CELL_W-1:0] rd_data_reg;
    logic [2*CELL_W-1:0] byp_data_reg;
    logic [2*CELL_W-1:0] wr_word;
    logic                byp_reg;
    logic                rd_ok_reg;
    logic                clr_busy_reg;
    logic [AW-1:0]       clr_addr_reg;

    assign line_data = byp_reg ? byp_data_reg : rd_data_reg;
    // shift the column down: middle moves to upper, new pixel into middle
    assign wr_word   = {line_data[CELL_W-1:0], wr_cell};
    assign ready     = rd_ok_reg && !clr_busy_reg;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            rd_ok_reg    <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= AW'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == AW'(MAX_COLS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            rd_ok_reg <= !clr_busy_reg && !hold;
            byp_reg   <= wr_en && !clr_busy_reg && (rd_addr == wr_addr);
        end
    end

endmodule

`default_nettype wire

### rtl/ssc_judge.sv
// Inflow count of the center cell of one 3x3 window of ids and directions.
// Depends on ssc_pkg for the neighbor offset tables.
`timescale 1ns / 1ps
`default_nettype none

module ssc_judge #(
    parameter int ID_BITS = ssc_pkg::ID_BITS_DEF
) (
    input  logic [ID_BITS-1:0]        win_id  [3][3],
    input  logic [ssc_pkg::DIR_W-1:0] win_dir [3][3],
    output logic                      hit,
    output logic [ssc_pkg::CNT_W-1:0] count
);
    import ssc_pkg::*;

    logic [ID_BITS-1:0] centre;
    logic [8:1]         drain_any;
    logic [8:1]         drain_same;
    logic [CNT_W-1:0]   n_any;
    logic [CNT_W-1:0]   n_same;

    assign centre = win_id[1][1];

    always_comb
    begin
        for (int i = 1; i < 9; i++)
        begin
            drain_any[i]  = (win_id[1 + ROW_OFF[i]][1 + COL_OFF[i]] != '0) &&
                            (win_dir[1 + ROW_OFF[i]][1 + COL_OFF[i]] == want_dir(i));
            drain_same[i] = (win_id[1 + ROW_OFF[i]][1 + COL_OFF[i]] == centre) &&
                            (win_dir[1 + ROW_OFF[i]][1 + COL_OFF[i]] == want_dir(i));
        end
    end

    always_comb
    begin
        n_any  = '0;
        n_same = '0;
        for (int i = 1; i < 9; i++)
        begin
            n_any  = CNT_W'(n_any + CNT_W'(drain_any[i]));
            n_same = CNT_W'(n_same + CNT_W'(drain_same[i]));
        end
        count = (n_any > CNT_W'(1)) ? CNT_W'(n_any - n_same) : n_any;
        hit   = (centre != '0) && (count != CNT_W'(1));
    end

endmodule

`default_nettype wire

### rtl/ssc_result_fifo.sv
// Small result word queue that takes up to two words a cycle and gives one.
// Depends on ssc_pkg for result_t and push_t.
`timescale 1ns / 1ps
`default_nettype none

module ssc_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  ssc_pkg::push_t   push,
    input  logic             pop,
    output ssc_pkg::result_t head,
    output logic             head_valid,
    output logic             room2
);
    import ssc_pkg::*;

    result_t           mem [RES_DEPTH];
    logic [RES_PW-1:0] wr_ptr_reg;
    logic [RES_PW-1:0] rd_ptr_reg;
    logic [RES_PW:0]   cnt_reg;
    logic [RES_PW:0]   cnt_next;

    assign head       = mem[rd_ptr_reg];
    assign head_valid = cnt_reg != '0;
    assign room2      = cnt_reg <= (RES_PW + 1)'(RES_DEPTH - 2);
    assign cnt_next   = (RES_PW + 1)'(cnt_reg + (RES_PW + 1)'(push.n) - (RES_PW + 1)'(pop));

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.a;
        end
        if (push.n == 2'd2)
        begin
            mem[RES_PW'(wr_ptr_reg + 1'b1)] <= push.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= RES_PW'(wr_ptr_reg + push.n);
            rd_ptr_reg <= RES_PW'(rd_ptr_reg + pop);
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/stream_source_cell_finder_core.sv
// A row's last pixel may yield two result words; each goes via the judge stage and queue.
// Throughput: one pixel word per cycle unless the line store or result queue stalls.
// The 3x3 window register feeds the inflow judges; one memory port pair has both lines.
// Reset: a sweep of MAX_COLS addresses clears the line stores, pixel ready stays low;
// ready also drops for one cycle after each row_width write.
`timescale 1ns / 1ps
`default_nettype none

module stream_source_cell_finder_core #(
    parameter int MAX_COLS = ssc_pkg::MAX_COLS_DEF,
    parameter int ID_BITS  = ssc_pkg::ID_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ssc_pkg::CFG_W-1:0]   cfg_wdata,
    ssc_pixel_if.sink                   pixel,
    ssc_result_if.source                result
);
    import ssc_pkg::*;

    localparam int CELL_W = ID_BITS + DIR_W;
    localparam int AW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [CFG_W-1:0]    rw_reg;
    logic [CFG_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [CFG_W-1:0]    eff_w;
    logic [CFG_W-1:0]    c_cur;
    logic [CFG_W-1:0]    c_after;
    logic                last_col;
    logic                accept;
    logic                line_ready;
    logic [2*CELL_W-1:0] line_data;
    logic [CELL_W-1:0]   new_cell;
    logic [AW-1:0]       rd_addr;

    logic [ID_BITS-1:0]  win_id_reg  [3][3];
    logic [DIR_W-1:0]    win_dir_reg [3][3];
    logic [ID_BITS-1:0]  edge_id     [3][3];
    logic [DIR_W-1:0]    edge_dir    [3][3];

    logic                s1_valid_reg;
    logic [CFG_W-1:0]    s1_col_reg;
    logic                s1_first_reg;
    logic                s1_edge_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic                s1_adv;

    logic                ja_hit;
    logic                jb_hit;
    logic [CNT_W-1:0]    ja_count;
    logic [CNT_W-1:0]    jb_count;
    logic                hit_a;
    logic                hit_b;
    result_t             res_a;
    result_t             res_b;
    push_t               push;
    result_t             head;
    logic                head_valid;
    logic                room2;

    always_comb
    begin
        eff_w = (rw_reg == '0) ? CFG_W'(1) : rw_reg;
        if (MAX_COLS < (1 << CFG_W) && 32'(eff_w) > MAX_COLS)
        begin
            eff_w = CFG_W'(MAX_COLS);
        end
    end

    assign c_cur    = (col_reg >= eff_w) ? '0 : col_reg;
    assign last_col = c_cur == CFG_W'(eff_w - 1'b1);
    assign c_after  = last_col ? '0 : CFG_W'(c_cur + 1'b1);
    assign rd_addr  = accept ? AW'(c_after) : AW'(c_cur);
    assign new_cell = pixel.padding ? '0
                    : {ID_BITS'(pixel.stream_id), DIR_W'(pixel.flow_dir)};

    assign s1_adv      = s1_valid_reg && room2;
    assign pixel.ready = line_ready && (!s1_valid_reg || room2);
    assign accept      = pixel.valid && pixel.ready;

    ssc_line_store #(
        .MAX_COLS (MAX_COLS),
        .CELL_W   (CELL_W)
    ) u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (cfg_we),
        .wr_en     (accept),
        .wr_addr   (AW'(c_cur)),
        .rd_addr   (rd_addr),
        .wr_cell   (new_cell),
        .line_data (line_data),
        .ready     (line_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg       <= ROW_WIDTH_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rw_reg  <= cfg_wdata;
                col_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= c_after;
            end
            if (accept && last_col)
            begin
                row_reg <= ROW_W'(row_reg + 1'b1);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_id_reg[r][0]  <= (c_cur == '0) ? '0 : win_id_reg[r][1];
                win_dir_reg[r][0] <= (c_cur == '0) ? '0 : win_dir_reg[r][1];
                win_id_reg[r][1]  <= (c_cur == '0) ? '0 : win_id_reg[r][2];
                win_dir_reg[r][1] <= (c_cur == '0) ? '0 : win_dir_reg[r][2];
            end
            {win_id_reg[0][2], win_dir_reg[0][2]} <= line_data[2*CELL_W-1:CELL_W];
            {win_id_reg[1][2], win_dir_reg[1][2]} <= line_data[CELL_W-1:0];
            {win_id_reg[2][2], win_dir_reg[2][2]} <= new_cell;
            s1_col_reg   <= c_cur;
            s1_first_reg <= c_cur != '0;
            s1_edge_reg  <= last_col;
            s1_row_reg   <= ROW_W'(row_reg - 1'b1);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            edge_id[r][0]  = win_id_reg[r][1];
            edge_dir[r][0] = win_dir_reg[r][1];
            edge_id[r][1]  = win_id_reg[r][2];
            edge_dir[r][1] = win_dir_reg[r][2];
            edge_id[r][2]  = '0;
            edge_dir[r][2] = '0;
        end
    end

    ssc_judge #(.ID_BITS(ID_BITS)) u_judge_a (
        .win_id  (win_id_reg),
        .win_dir (win_dir_reg),
        .hit     (ja_hit),
        .count   (ja_count)
    );

    ssc_judge #(.ID_BITS(ID_BITS)) u_judge_b (
        .win_id  (edge_id),
        .win_dir (edge_dir),
        .hit     (jb_hit),
        .count   (jb_count)
    );

    always_comb
    begin
        hit_a = s1_first_reg && ja_hit;
        hit_b = s1_edge_reg && jb_hit;

        res_a.cell_row      = s1_row_reg;
        res_a.cell_col      = COL_W'(s1_col_reg - 1'b1);
        res_a.cell_stream   = ID_W'(win_id_reg[1][1]);
        res_a.inflow_count  = ja_count;
        res_a.dense_flag    = ja_count > DENSE_LIMIT;
        res_a.mismatch_flag = ja_count > MISMATCH_LIMIT;
        res_a.last          = !hit_b;

        res_b.cell_row      = s1_row_reg;
        res_b.cell_col      = COL_W'(s1_col_reg);
        res_b.cell_stream   = ID_W'(win_id_reg[1][2]);
        res_b.inflow_count  = jb_count;
        res_b.dense_flag    = jb_count > DENSE_LIMIT;
        res_b.mismatch_flag = jb_count > MISMATCH_LIMIT;
        res_b.last          = 1'b1;

        push.n = s1_adv ? {hit_a && hit_b, hit_a ^ hit_b} : 2'd0;
        push.a = hit_a ? res_a : res_b;
        push.b = res_b;
    end

    ssc_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (head_valid && result.ready),
        .head       (head),
        .head_valid (head_valid),
        .room2      (room2)
    );

    assign result.valid         = head_valid;
    assign result.cell_row      = head.cell_row;
    assign result.cell_col      = head.cell_col;
    assign result.cell_stream   = head.cell_stream;
    assign result.inflow_count  = head.inflow_count;
    assign result.dense_flag    = head.dense_flag;
    assign result.mismatch_flag = head.mismatch_flag;
    assign result.last          = head.last;

    a_cfg_blocks_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !pixel.ready)
        else $error("pixel taken right after a row_width write");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel word lost before the judge stage");

    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_col |=> row_reg == ROW_W'($past(row_reg) + 1'b1))
        else $error("row counter did not advance at end of row");

    a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && hit_a && hit_b |=> result.valid)
        else $error("two result words pushed but none offered");

endmodule

`default_nettype wire

### tb/stream_source_cell_finder_core_tb.sv
// Self-checking bench for stream_source_cell_finder_core: a scripted raster, then random
// rasters over several row widths, each result word checked against the script or a local
// window model. Depends on ssc_pkg and the pixel/result interfaces in ssc_stream_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module stream_source_cell_finder_core_tb;
    import ssc_pkg::*;

    typedef enum logic [DIR_W-1:0] {
        D_NONE = 5'd0,
        D_NE   = 5'd1,
        D_N    = 5'd2,
        D_NW   = 5'd3,
        D_W    = 5'd4,
        D_SW   = 5'd5,
        D_S    = 5'd6,
        D_SE   = 5'd7,
        D_E    = 5'd8,
        D_MIN  = 5'b11000,
        D_BACK = 5'b11111
    } dir_e;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_PIXEL
    } step_e;

    typedef struct packed {
        bit [ID_W-1:0]  id;
        bit [DIR_W-1:0] dir;
    } px_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DIR_W-1:0] dir;
        logic             pad;
    } pixel_word_t;

    typedef struct packed {
        step_e       kind;
        logic [15:0] id;
        dir_e        dir;
        logic        pad;
        logic        typed;
        logic [1:0]  n_res;
        result_t     res;
    } script_row_t;

    localparam result_t NO_CELL = '0;
    localparam result_t SOURCE_CELL = '{16'd0, 12'd1, 16'hFFFF, 4'd0, 1'b0, 1'b0, 1'b1};

    localparam int NB_ROW [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
    localparam int NB_COL [8] = '{1, 0, -1, -1, -1, 0, 1, 1};
    localparam dir_e NB_DRAIN [8] = '{D_SW, D_S, D_SE, D_E, D_NE, D_N, D_NW, D_W};

    localparam int SCRIPT_LEN = 25;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{STEP_CFG,   16'd3,    D_NONE, 1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0000, D_NONE, 1'b0, 1'b1, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'hFFFF, D_NONE, 1'b0, 1'b1, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0000, D_NONE, 1'b0, 1'b1, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0001, D_SE,   1'b0, 1'b1, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0001, D_S,    1'b0, 1'b1, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0001, D_SW,   1'b0, 1'b1, 2'd1, SOURCE_CELL},
        '{STEP_PIXEL, 16'h0001, D_E,    1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h8000, D_BACK, 1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0001, D_W,    1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0001, D_NE,   1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0001, D_N,    1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0001, D_NW,   1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'hFFFF, D_N,    1'b1, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h1234, D_MIN,  1'b1, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0001, D_E,    1'b1, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0005, D_SE,   1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0007, D_S,    1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0009, D_SW,   1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0000, D_NONE, 1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0005, D_MIN,  1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0000, D_E,    1'b0, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h0000, D_NONE, 1'b1, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'hABCD, D_BACK, 1'b1, 1'b0, 2'd0, NO_CELL},
        '{STEP_PIXEL, 16'h5555, D_NE,   1'b1, 1'b0, 2'd0, NO_CELL}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    ssc_pixel_if  pixel_ch ();
    ssc_result_if result_ch ();

    stream_source_cell_finder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    px_t              upper_mem [MAX_COLS_DEF];
    px_t              middle_mem [MAX_COLS_DEF];
    px_t              window_px [3][3];
    bit [ROW_W-1:0]   row_pos;
    int unsigned      col_pos;
    bit [CFG_W-1:0]   width_reg = ROW_WIDTH_RESET;

    result_t          pending_cells [$];
    int               bad_cells;
    int               pix_gap_pct;
    int               res_stall_pct;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned eff_span(input int unsigned v);
        if (v == 0)
            return 1;
        if (v > MAX_COLS_DEF)
            return MAX_COLS_DEF;
        return v;
    endfunction

    function automatic px_t window_at(input int rr, input int cc);
        if (cc > 2)
            return '0;
        return window_px[rr][cc];
    endfunction

    // judge the window center, or with shift 1 the row-end cell beside it
    function automatic bit judge_cell(input int shift, input logic [COL_W-1:0] col,
                                      output result_t found);
        px_t         ctr;
        px_t         nb;
        int unsigned cnt;
        found = '0;
        ctr = window_px[1][1 + shift];
        if (ctr.id == 0)
            return 1'b0;
        cnt = 0;
        for (int i = 0; i < 8; i++)
        begin
            nb = window_at(1 + NB_ROW[i], 1 + shift + NB_COL[i]);
            if (nb.id != 0 && nb.dir == NB_DRAIN[i])
                cnt++;
        end
        if (cnt > 1)
        begin
            for (int i = 0; i < 8; i++)
            begin
                nb = window_at(1 + NB_ROW[i], 1 + shift + NB_COL[i]);
                if (nb.id == ctr.id && nb.dir == NB_DRAIN[i])
                    cnt--;
            end
        end
        if (cnt == 1)
            return 1'b0;
        found.cell_row      = row_pos - 1'b1;
        found.cell_col      = col;
        found.cell_stream   = ctr.id;
        found.inflow_count  = CNT_W'(cnt);
        found.dense_flag    = (cnt > DENSE_LIMIT);
        found.mismatch_flag = (cnt > MISMATCH_LIMIT);
        found.last          = 1'b0;
        return 1'b1;
    endfunction

    function automatic void advance_raster(input pixel_word_t w, input bit keep);
        int unsigned span;
        int unsigned c;
        int          n;
        px_t         fresh;
        result_t     cells [2];
        span = eff_span(width_reg);
        c = (col_pos >= span) ? 0 : col_pos;
        fresh = '0;
        if (!w.pad)
        begin
            fresh.id  = w.id;
            fresh.dir = w.dir;
        end
        if (c == 0)
            window_px = '{default: '0};
        for (int rr = 0; rr < 3; rr++)
        begin
            window_px[rr][0] = window_px[rr][1];
            window_px[rr][1] = window_px[rr][2];
        end
        window_px[0][2] = upper_mem[c];
        window_px[1][2] = middle_mem[c];
        window_px[2][2] = fresh;
        upper_mem[c] = middle_mem[c];
        middle_mem[c] = fresh;
        n = 0;
        if (c >= 1 && judge_cell(0, COL_W'(c - 1), cells[n]))
            n++;
        if (c == span - 1 && judge_cell(1, COL_W'(c), cells[n]))
            n++;
        if (n > 0)
            cells[n - 1].last = 1'b1;
        if (keep)
            for (int k = 0; k < n; k++)
                pending_cells.push_back(cells[k]);
        if (c + 1 >= span)
        begin
            col_pos = 0;
            row_pos = row_pos + 1'b1;
        end
        else
            col_pos = c + 1;
    endfunction

    function automatic pixel_word_t random_pixel(input int density);
        pixel_word_t w;
        int unsigned pick;
        w.pad = ($urandom_range(39) == 0);
        w.id = '0;
        if ($urandom_range(99) < density)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                w.id = ID_W'($urandom_range(3, 1));
            else if (pick < 65)
                w.id = 16'hFFFF;
            else
                w.id = ID_W'($urandom_range(16'hFFFF, 1));
        end
        if ($urandom_range(4) != 0)
            w.dir = DIR_W'($urandom_range(8, 1));
        else
            w.dir = DIR_W'($urandom_range(16) - 8);
        return w;
    endfunction

    function automatic string cell_text(input result_t c);
        return $sformatf("row %0d col %0d stream %0h count %0d dense %0b mismatch %0b last %0b",
                         c.cell_row, c.cell_col, c.cell_stream, c.inflow_count,
                         c.dense_flag, c.mismatch_flag, c.last);
    endfunction

    task automatic send_pixel(input pixel_word_t w, input bit typed,
                              input logic [1:0] typed_n, input result_t typed_res);
        while ($urandom_range(99) < pix_gap_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid     <= 1'b1;
        pixel_ch.stream_id <= w.id;
        pixel_ch.flow_dir  <= w.dir;
        pixel_ch.padding   <= w.pad;
        do
            @(posedge clk);
        while (pixel_ch.ready !== 1'b1);
        advance_raster(w, !typed);
        if (typed && typed_n != 0)
            pending_cells.push_back(typed_res);
    endtask

    task automatic settle();
        pixel_ch.valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_row_width(input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_reg = v;
        col_pos = 0;
    endtask

    task automatic run_raster(input int unsigned width_val, input int rows, input int tail,
                              input int density, input bit flush);
        int unsigned span;
        pixel_word_t w;
        span = eff_span(width_val);
        write_row_width(CFG_W'(width_val));
        repeat (rows * span + tail)
            send_pixel(random_pixel(density), 1'b0, 2'd0, NO_CELL);
        if (flush)
        begin
            repeat (span)
            begin
                w = random_pixel(density);
                w.pad = 1'b1;
                send_pixel(w, 1'b0, 2'd0, NO_CELL);
            end
        end
        settle();
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_ch.ready <= ($urandom_range(99) >= res_stall_pct);
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got = {result_ch.cell_row, result_ch.cell_col, result_ch.cell_stream,
                   result_ch.inflow_count, result_ch.dense_flag, result_ch.mismatch_flag,
                   result_ch.last};
            if (pending_cells.size() == 0)
            begin
                bad_cells++;
                $display("%0t: unexpected word, expected none, got %s",
                         $time, cell_text(got));
            end
            else
            begin
                want = pending_cells.pop_front();
                if (got !== want)
                begin
                    bad_cells++;
                    $display("%0t: expected %s, got %s",
                             $time, cell_text(want), cell_text(got));
                end
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        pixel_ch.valid     <= 1'b0;
        pixel_ch.stream_id <= '0;
        pixel_ch.flow_dir  <= '0;
        pixel_ch.padding   <= 1'b0;
        bad_cells = 0;
        pix_gap_pct = 20;
        res_stall_pct = 81;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // hold off until the line store clear has finished
        do
            @(posedge clk);
        while (pixel_ch.ready !== 1'b1);

        for (int k = 0; k < SCRIPT_LEN; k++)
        begin
            if (SCRIPT[k].kind == STEP_CFG)
                write_row_width(SCRIPT[k].id[CFG_W-1:0]);
            else
                send_pixel({SCRIPT[k].id, SCRIPT[k].dir, SCRIPT[k].pad},
                           SCRIPT[k].typed, SCRIPT[k].n_res, SCRIPT[k].res);
        end
        settle();

        run_raster(5, 12, 2, 60, 1'b1);
        run_raster(1, 40, 0, 60, 1'b1);
        run_raster(7, 20, 3, 70, 1'b1);
        run_raster(2, 30, 1, 60, 1'b1);
        run_raster(16, 10, 0, 70, 1'b1);

        pix_gap_pct = 81;
        res_stall_pct = 20;
        run_raster(33, 8, 5, 60, 1'b1);
        run_raster(3, 40, 0, 70, 1'b0);
        run_raster(13, 12, 7, 60, 1'b1);
        run_raster(MAX_COLS_DEF, 0, 150, 60, 1'b0);
        run_raster(64, 3, 20, 60, 1'b1);

        pix_gap_pct = 0;
        res_stall_pct = 0;
        run_raster(8191, 0, 100, 50, 1'b0);
        // one-column rows
        run_raster(0, 150, 0, 12, 1'b1);

        if (bad_cells == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/ssc_pkg.sv
rtl/ssc_stream_if.sv
rtl/ssc_line_store.sv
rtl/ssc_judge.sv
rtl/ssc_result_fifo.sv
rtl/stream_source_cell_finder_core.sv
tb/stream_source_cell_finder_core_tb.sv
